[rtl/core/flood_duplicate_filter_top_assert.svh]
// assertion macros for the duplicate filter
`ifndef FLOOD_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define FLOOD_DUPLICATE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define FDF_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdf assertion failed");

// next-cycle implication
`define FDF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdf assertion failed");

`endif

[rtl/core/fdf_pkg.sv]
`default_nettype none

package fdf_pkg;

    localparam int HISTORY_DEPTH = 20;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [1:0]
    {
        ACT_DROP = 2'd0,
        ACT_ORIG = 2'd1,
        ACT_FWD  = 2'd2
    } action_t;

    typedef struct packed
    {
        logic [15:0] origin;
        logic [15:0] signature;
    } entry_t;

    typedef struct packed
    {
        logic [15:0] origin_node;
        logic [15:0] signature;
        logic [7:0]  deliver_port;
        logic [7:0]  previous_hop;
    } req_t;

    typedef struct packed
    {
        action_t     action;
        logic [7:0]  local_port;
        logic [7:0]  stamp_low;
        logic [7:0]  stamp_high;
        logic        stamp_high_write;
        logic [15:0] originated_count;
        logic [15:0] forwarded_count;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/fdf_hist_mem.sv]
`default_nettype none

module fdf_hist_mem
    import fdf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [HISTORY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/fdf_ctrl.sv]
`default_nettype none

module fdf_ctrl
    import fdf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [15:0]      own_id,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire req_t             in_data,
    output logic                  mem_rd_en,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  wire entry_t           mem_rd_data,
    output logic                  mem_wr_en,
    output logic [IDX_W-1:0]      mem_wr_addr,
    output entry_t                mem_wr_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output res_t                  res
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t                   state_reg, state_next;
    req_t                     key_reg, key_next;
    logic [CNT_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic                     cmp_en_reg, cmp_en_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                     hit_reg, hit_next;
    logic [HISTORY_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]         slot_reg, slot_next;
    logic [15:0]              orig_cnt_reg, orig_cnt_next;
    logic [15:0]              fwd_cnt_reg, fwd_cnt_next;

    action_t                  action;
    logic                     adjacent;
    logic [16:0]              hop_ext;
    logic [16:0]              own_ext;

    // neighbor test on ids widened to 17 bits, then the action for the item
    always_comb
    begin
        hop_ext  = {9'd0, key_reg.previous_hop};
        own_ext  = {1'b0, own_id};
        adjacent = ((own_id != 16'd0) && (hop_ext == (own_ext - 17'd1)))
                || (hop_ext == (own_ext + 17'd1));
        if (hit_reg)
        begin
            action = ACT_DROP;
        end
        else if (key_reg.origin_node == own_id)
        begin
            action = ACT_ORIG;
        end
        else if (adjacent)
        begin
            action = ACT_FWD;
        end
        else
        begin
            action = ACT_DROP;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_en_next   = cmp_en_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        valid_next    = valid_reg;
        slot_next     = slot_reg;
        orig_cnt_next = orig_cnt_reg;
        fwd_cnt_next  = fwd_cnt_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = scan_cnt_reg[IDX_W-1:0];
        mem_wr_en     = 1'b0;
        mem_wr_addr   = slot_reg;
        mem_wr_data   = '{origin: key_reg.origin_node, signature: key_reg.signature};
        in_ready      = (state_reg == ST_IDLE);
        res_valid     = (state_reg == ST_DECIDE);

        // compare the entry read last cycle
        if (cmp_en_reg && valid_reg[cmp_idx_reg]
            && (mem_rd_data.origin == key_reg.origin_node)
            && (mem_rd_data.signature == key_reg.signature))
        begin
            hit_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next      = in_data;
                    scan_cnt_next = '0;
                    cmp_en_next   = 1'b0;
                    hit_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg != CNT_W'(HISTORY_DEPTH))
                begin
                    mem_rd_en     = 1'b1;
                    cmp_en_next   = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_en_next = 1'b0;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                    if (action != ACT_DROP)
                    begin
                        mem_wr_en            = 1'b1;
                        valid_next[slot_reg] = 1'b1;
                        if (slot_reg == IDX_W'(HISTORY_DEPTH - 1))
                        begin
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + IDX_W'(1);
                        end
                    end
                    if (action == ACT_ORIG)
                    begin
                        orig_cnt_next = orig_cnt_reg + 16'd1;
                    end
                    if (action == ACT_FWD)
                    begin
                        fwd_cnt_next = fwd_cnt_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result of the item in decision
    always_comb
    begin
        res.action           = action;
        res.local_port       = (action == ACT_FWD) ? key_reg.deliver_port : 8'd0;
        res.stamp_low        = (action != ACT_DROP) ? own_id[7:0] : 8'd0;
        res.stamp_high       = (action == ACT_ORIG) ? own_id[15:8] : 8'd0;
        res.stamp_high_write = (action == ACT_ORIG);
        res.originated_count = (action == ACT_ORIG) ? (orig_cnt_reg + 16'd1) : orig_cnt_reg;
        res.forwarded_count  = (action == ACT_FWD) ? (fwd_cnt_reg + 16'd1) : fwd_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            key_reg      <= '0;
            scan_cnt_reg <= '0;
            cmp_en_reg   <= 1'b0;
            cmp_idx_reg  <= '0;
            hit_reg      <= 1'b0;
            valid_reg    <= '0;
            slot_reg     <= '0;
            orig_cnt_reg <= '0;
            fwd_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            key_reg      <= key_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_en_reg   <= cmp_en_next;
            cmp_idx_reg  <= cmp_idx_next;
            hit_reg      <= hit_next;
            valid_reg    <= valid_next;
            slot_reg     <= slot_next;
            orig_cnt_reg <= orig_cnt_next;
            fwd_cnt_reg  <= fwd_cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/flood_duplicate_filter_top.sv]
// a request is taken only while idle; the history memory is then scanned
//   through its single read port, one entry per cycle, and the decision is
//   registered at the output before the next request is taken
// reset: valid marks, ring slot, both counters and own id clear at once;
//   no clearing pass, the block takes a request right after reset
`default_nettype none
`include "flood_duplicate_filter_top_assert.svh"

module flood_duplicate_filter_top
    import fdf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // origin_node, signature, deliver_port, previous_hop
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // local_port, stamp_low, stamp_high, stamp_high_write, originated_count,
    // forwarded_count, zero fill
    output logic [63:0]      m_axis_tdata,
    // action
    output logic [1:0]       m_axis_tuser
);

    logic [15:0]      own_id_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;

    req_t             req;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;

    assign req.origin_node  = s_axis_tdata[15:0];
    assign req.signature    = s_axis_tdata[31:16];
    assign req.deliver_port = s_axis_tdata[39:32];
    assign req.previous_hop = s_axis_tdata[47:40];

    assign res_ready = !out_valid_reg || m_axis_tready;

    fdf_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .own_id      (own_id_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (req),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    fdf_hist_mem u_hist_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                own_id_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.action;
    assign m_axis_tdata  = {7'd0,
                            out_res_reg.forwarded_count,
                            out_res_reg.originated_count,
                            out_res_reg.stamp_high_write,
                            out_res_reg.stamp_high,
                            out_res_reg.stamp_low,
                            out_res_reg.local_port};

    `FDF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FDF_ASSERT_SAME(a_write_only_on_keep, mem_wr_en, res_valid && res_ready && (res.action != ACT_DROP))
    `FDF_ASSERT_SAME(a_high_stamp_on_orig, m_axis_tvalid, m_axis_tdata[24] == (m_axis_tuser == ACT_ORIG))

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fdf_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int RECENT_MAX  = 32;

    typedef struct
    {
        logic [15:0] origin;
        logic [15:0] signature;
        logic [7:0]  port;
        logic [7:0]  hop;
    } header_t;

    typedef struct
    {
        action_t     action;
        logic [7:0]  local_port;
        logic [7:0]  stamp_low;
        logic [7:0]  stamp_high;
        logic        stamp_high_write;
        logic [15:0] originated;
        logic [15:0] forwarded;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    header_t  pending_headers[$];
    verdict_t expected_verdicts[$];
    header_t  recent_pairs[$];

    // flood filter state as seen by the testbench
    logic        hist_valid [HISTORY_DEPTH];
    logic [15:0] hist_origin [HISTORY_DEPTH];
    logic [15:0] hist_sig [HISTORY_DEPTH];
    int          ring_slot;
    logic [15:0] orig_cnt;
    logic [15:0] fwd_cnt;
    logic [15:0] node_id;

    header_t  on_wire;
    verdict_t want;
    int       send_gap;
    int       stall_left;
    int       holds_asked;
    int       holds_done;
    int       quiet;
    int       faults;
    logic     gaps_on;

    flood_duplicate_filter_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic judge_header(input header_t h);
        verdict_t    v;
        logic        seen;
        logic [16:0] own_w;
        logic [16:0] hop_w;
        logic        fresh_own;
        logic        adjacent;
        seen = 1'b0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            if (hist_valid[k] && hist_origin[k] == h.origin && hist_sig[k] == h.signature)
                seen = 1'b1;
        end
        own_w = {1'b0, node_id};
        hop_w = {9'b0, h.hop};
        fresh_own = !seen && h.origin == node_id;
        adjacent = (node_id != 16'd0 && hop_w == own_w - 17'd1) || hop_w == own_w + 17'd1;
        v.action = ACT_DROP;
        v.local_port = '0;
        v.stamp_low = '0;
        v.stamp_high = '0;
        v.stamp_high_write = 1'b0;
        if (fresh_own || (!seen && adjacent))
        begin
            hist_valid[ring_slot] = 1'b1;
            hist_origin[ring_slot] = h.origin;
            hist_sig[ring_slot] = h.signature;
            ring_slot = (ring_slot == HISTORY_DEPTH - 1) ? 0 : ring_slot + 1;
            v.stamp_low = node_id[7:0];
            if (fresh_own)
            begin
                v.action = ACT_ORIG;
                v.stamp_high = node_id[15:8];
                v.stamp_high_write = 1'b1;
                orig_cnt = orig_cnt + 16'd1;
            end
            else
            begin
                v.action = ACT_FWD;
                v.local_port = h.port;
                fwd_cnt = fwd_cnt + 16'd1;
            end
        end
        v.originated = orig_cnt;
        v.forwarded = fwd_cnt;
        expected_verdicts.push_back(v);
    endtask

    task automatic add_header(input logic [15:0] o, input logic [15:0] s,
                              input logic [7:0] p, input logic [7:0] h);
        header_t x;
        x.origin = o;
        x.signature = s;
        x.port = p;
        x.hop = h;
        pending_headers.push_back(x);
        recent_pairs.push_back(x);
        if (recent_pairs.size() > RECENT_MAX)
            void'(recent_pairs.pop_front());
    endtask

    function automatic logic [7:0] adjacent_hop(input logic [15:0] own);
        int lo;
        int hi;
        lo = int'(own) - 1;
        hi = int'(own) + 1;
        if (lo >= 0 && lo <= 255 && hi <= 255)
            return ($urandom_range(0, 1) != 0) ? 8'(lo) : 8'(hi);
        else if (hi <= 255)
            return 8'(hi);
        else if (lo >= 0 && lo <= 255)
            return 8'(lo);
        else
            return 8'($urandom);
    endfunction

    task automatic add_random_header(input logic [15:0] own);
        int          kind;
        header_t     r;
        logic [15:0] o;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            add_header(own, 16'($urandom), 8'($urandom), 8'($urandom));
        else if (kind < 55)
        begin
            o = 16'($urandom);
            if (o == own)
                o = ~o;
            add_header(o, 16'($urandom), 8'($urandom), adjacent_hop(own));
        end
        else if (kind < 80 && recent_pairs.size() > 0)
        begin
            r = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
            add_header(r.origin, r.signature, 8'($urandom),
                       ($urandom_range(0, 3) != 0) ? adjacent_hop(own) : 8'($urandom));
        end
        else
            add_header(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_headers.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_node_id(input logic [15:0] v);
        wait_idle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        node_id = v;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                judge_header(on_wire);
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_headers.size() > 0)
            begin
                on_wire = pending_headers.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {on_wire.hop, on_wire.port, on_wire.signature, on_wire.origin};
                send_gap = gaps_on ? pick_gap() : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected result: action %0d data %h", m_axis_tuser,
                                 m_axis_tdata);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (m_axis_tuser != want.action || m_axis_tdata[7:0] != want.local_port
                        || m_axis_tdata[15:8] != want.stamp_low
                        || m_axis_tdata[23:16] != want.stamp_high
                        || m_axis_tdata[24] != want.stamp_high_write
                        || m_axis_tdata[40:25] != want.originated
                        || m_axis_tdata[56:41] != want.forwarded)
                    begin
                        faults++;
                        if (faults <= 10)
                            $display("mismatch: exp act %0d port %h lo %h hi %h wr %0d org %0d fwd %0d / got act %0d port %h lo %h hi %h wr %0d org %0d fwd %0d",
                                     want.action, want.local_port, want.stamp_low,
                                     want.stamp_high, want.stamp_high_write, want.originated,
                                     want.forwarded, m_axis_tuser, m_axis_tdata[7:0],
                                     m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tdata[24],
                                     m_axis_tdata[40:25], m_axis_tdata[56:41]);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (holds_done < holds_asked)
            begin
                holds_done++;
                stall_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] id_list [12];
        logic [15:0] own;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            hist_valid[k] = 1'b0;
            hist_origin[k] = '0;
            hist_sig[k] = '0;
        end
        ring_slot = 0;
        orig_cnt = '0;
        fwd_cnt = '0;
        node_id = '0;
        holds_asked = 0;
        holds_done = 0;
        quiet = 0;
        faults = 0;
        gaps_on = 1'b1;
        id_list = '{16'h0000, 16'h0001, 16'h0002, 16'h007F, 16'h00FE, 16'h00FF,
                    16'h0100, 16'h0101, 16'hFFFF, 16'h8000, 16'h0055, 16'h00AA};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // own id still at its reset value of zero
        add_header(16'h0000, 16'h1234, 8'hAA, 8'hFF);
        add_header(16'h0000, 16'h1234, 8'h00, 8'h01);
        add_header(16'hFFFF, 16'hFFFF, 8'hFF, 8'h01);
        add_header(16'h0005, 16'h0001, 8'h03, 8'h00);
        add_header(16'hFFFF, 16'hFFFF, 8'hFF, 8'h01);
        set_node_id(16'h0001);
        add_header(16'h0001, 16'h0000, 8'h00, 8'h80);
        add_header(16'h0002, 16'h0002, 8'h11, 8'h00);
        add_header(16'h0003, 16'h0003, 8'h22, 8'h02);
        add_header(16'h0004, 16'h0004, 8'h33, 8'h03);
        add_header(16'h0000, 16'h1234, 8'h44, 8'h00);
        set_node_id(16'h0100);
        add_header(16'h0009, 16'h0009, 8'h44, 8'hFF);
        add_header(16'h0100, 16'hABCD, 8'h00, 8'h00);
        set_node_id(16'hFFFF);
        add_header(16'hFFFF, 16'h0000, 8'h00, 8'hFF);
        add_header(16'hFFFF, 16'h0000, 8'h00, 8'h00);
        add_header(16'h1234, 16'h5678, 8'h99, 8'hFF);
        add_header(16'h1234, 16'h5678, 8'h99, 8'hFE);
        set_node_id(16'h00FF);
        add_header(16'h0008, 16'h0008, 8'h01, 8'hFE);
        add_header(16'h0008, 16'h0009, 8'h01, 8'h00);

        for (int ph = 0; ph < 16; ph++)
        begin
            own = (ph < 12) ? id_list[ph] : 16'($urandom_range(0, 300));
            set_node_id(own);
            gaps_on = (ph % 4 != 1);
            if (ph == 5)
                holds_asked++;
            repeat (100) add_random_header(own);
        end

        wait_idle();
        repeat (30) @(posedge clk);
        faults += expected_verdicts.size();
        if (faults == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
